>>> rtl/fjot_pkg.sv
// Shared types, codes and helpers for the flat JSON object tokenizer.
`timescale 1ns / 1ps

package fjot_pkg;

    localparam int unsigned CountWidth = 10;
    localparam logic [CountWidth-1:0] MaxPairsReset = 10'd100;

    localparam logic [7:0] ChOpen      = 8'h7B;
    localparam logic [7:0] ChClose     = 8'h7D;
    localparam logic [7:0] ChColon     = 8'h3A;
    localparam logic [7:0] ChComma     = 8'h2C;
    localparam logic [7:0] ChQuote     = 8'h22;
    localparam logic [7:0] ChBackslash = 8'h5C;
    localparam logic [7:0] ChEnd       = 8'h00;
    localparam logic [7:0] ChSpace     = 8'h20;
    localparam logic [7:0] ChTab       = 8'h09;
    localparam logic [7:0] ChCr        = 8'h0D;

    typedef enum logic [3:0] {
        ST_WAIT_OPEN   = 4'd0,
        ST_WANT_KEY    = 4'd1,
        ST_KEY         = 4'd2,
        ST_KEY_ESC     = 4'd3,
        ST_WANT_COLON  = 4'd4,
        ST_WANT_VALUE  = 4'd5,
        ST_VALUE       = 4'd6,
        ST_VALUE_ESC   = 4'd7,
        ST_AFTER_VALUE = 4'd8,
        ST_DONE        = 4'd9
    } t_parse_state;

    typedef enum logic [1:0] {
        ROLE_OTHER = 2'd0,
        ROLE_KEY   = 2'd1,
        ROLE_VALUE = 2'd2
    } t_role;

    typedef enum logic [1:0] {
        V_PROGRESS = 2'd0,
        V_ACCEPT   = 2'd1,
        V_ERROR    = 2'd2
    } t_verdict;

    typedef struct packed {
        t_role                 role;
        logic [7:0]            content;
        logic                  esc;
        logic [CountWidth-1:0] idx;
        logic                  done;
        t_verdict              verdict;
        logic [CountWidth-1:0] found;
    } t_result;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
    endfunction

endpackage

>>> rtl/flat_json_object_tokenizer.sv
// Top level of the flat JSON object tokenizer: state, config and result registers.
//
//   channel | valid       | ready        | payload
//   --------+-------------+--------------+-----------------------------------------
//   in      | i_in_valid  | o_in_ready   | i_text_byte
//   out     | o_out_valid | i_out_ready  | o_byte_role .. o_pairs_found
//   cfg     | i_cfg_valid | o_cfg_ready  | i_cfg_pair_limit
//
// One byte per cycle while the output is not stalled: each byte is decoded in the cycle it
// is accepted and its result sits in the output register on the next cycle.
// A new byte is taken whenever the output register is empty or being drained.
// A stalled output holds the result and blocks input; no bytes are lost.
// Reset (synchronous, active low) clears state, pair count and sets the pair limit to 100.
`timescale 1ns / 1ps

module flat_json_object_tokenizer
    import fjot_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CountWidth-1:0] i_cfg_pair_limit,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [7:0]            i_text_byte,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [1:0]            o_byte_role,
    output logic [7:0]            o_content_byte,
    output logic                  o_escaped,
    output logic [CountWidth-1:0] o_pair_index,
    output logic                  o_pair_done,
    output logic [1:0]            o_verdict,
    output logic [CountWidth-1:0] o_pairs_found
);

    t_parse_state          r_state;
    t_parse_state          n_state;
    logic [CountWidth-1:0] r_count;
    logic [CountWidth-1:0] n_count;
    logic [CountWidth-1:0] r_pair_limit;
    logic                  r_out_valid;
    t_result               r_result;
    t_result               n_result;
    logic                  in_accept;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_accept   = i_in_valid && o_in_ready;

    fjot_step u_step (
        .i_state      (r_state),
        .i_count      (r_count),
        .i_pair_limit (r_pair_limit),
        .i_byte       (i_text_byte),
        .o_state      (n_state),
        .o_count      (n_count),
        .o_result     (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_WAIT_OPEN;
            r_count      <= '0;
            r_pair_limit <= MaxPairsReset;
            r_out_valid  <= 1'b0;
            r_result     <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_pair_limit <= i_cfg_pair_limit;
            end
            if (in_accept) begin
                r_state     <= n_state;
                r_count     <= n_count;
                r_result    <= n_result;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_byte_role    = r_result.role;
    assign o_content_byte = r_result.content;
    assign o_escaped      = r_result.esc;
    assign o_pair_index   = r_result.idx;
    assign o_pair_done    = r_result.done;
    assign o_verdict      = r_result.verdict;
    assign o_pairs_found  = r_result.found;

endmodule

>>> rtl/fjot_step.sv
// Per-byte decode: next parse state, next pair count and the result item.
`timescale 1ns / 1ps

module fjot_step
    import fjot_pkg::*;
(
    input  t_parse_state          i_state,
    input  logic [CountWidth-1:0] i_count,
    input  logic [CountWidth-1:0] i_pair_limit,
    input  logic [7:0]            i_byte,
    output t_parse_state          o_state,
    output logic [CountWidth-1:0] o_count,
    output t_result               o_result
);

    always_comb begin
        o_state  = i_state;
        o_count  = i_count;
        o_result = '0;

        if (i_byte == ChEnd) begin
            o_result.verdict = (i_state != ST_DONE) ? V_ERROR : V_PROGRESS;
        end else begin
            unique case (i_state)
                ST_WAIT_OPEN: begin
                    if (i_byte == ChOpen) begin
                        o_state = ST_WANT_KEY;
                    end else if (!is_ws(i_byte)) begin
                        o_result.verdict = V_ERROR;
                    end
                end
                ST_WANT_KEY, ST_AFTER_VALUE: begin
                    if (is_ws(i_byte)) begin
                        o_state = i_state;
                    end else if (i_byte == ChQuote) begin
                        if (i_count >= i_pair_limit) begin
                            o_result.verdict = V_ERROR;
                        end else begin
                            o_state = ST_KEY;
                        end
                    end else if (i_byte == ChClose) begin
                        o_result.verdict = V_ACCEPT;
                    end else if (i_byte == ChComma && i_state == ST_AFTER_VALUE) begin
                        o_state = ST_WANT_KEY;
                    end else begin
                        o_result.verdict = V_ERROR;
                    end
                end
                ST_KEY, ST_VALUE: begin
                    if (i_byte == ChQuote) begin
                        if (i_state == ST_KEY) begin
                            o_state = ST_WANT_COLON;
                        end else begin
                            o_result.done = 1'b1;
                            o_result.idx  = i_count;
                            o_count       = i_count + 1'b1;
                            o_state       = ST_AFTER_VALUE;
                        end
                    end else begin
                        o_result.role    = (i_state == ST_KEY) ? ROLE_KEY : ROLE_VALUE;
                        o_result.content = i_byte;
                        o_result.idx     = i_count;
                        if (i_byte == ChBackslash) begin
                            o_state = (i_state == ST_KEY) ? ST_KEY_ESC : ST_VALUE_ESC;
                        end
                    end
                end
                ST_KEY_ESC, ST_VALUE_ESC: begin
                    o_result.role    = (i_state == ST_KEY_ESC) ? ROLE_KEY : ROLE_VALUE;
                    o_result.content = i_byte;
                    o_result.esc     = 1'b1;
                    o_result.idx     = i_count;
                    o_state          = (i_state == ST_KEY_ESC) ? ST_KEY : ST_VALUE;
                end
                ST_WANT_COLON: begin
                    if (i_byte == ChColon) begin
                        o_state = ST_WANT_VALUE;
                    end else if (!is_ws(i_byte)) begin
                        o_result.verdict = V_ERROR;
                    end
                end
                ST_WANT_VALUE: begin
                    if (i_byte == ChQuote) begin
                        o_state = ST_VALUE;
                    end else if (!is_ws(i_byte)) begin
                        o_result.verdict = V_ERROR;
                    end
                end
                default: begin
                    o_state = ST_DONE;
                end
            endcase
            if (o_result.verdict != V_PROGRESS) begin
                o_state = ST_DONE;
            end
        end

        o_result.found = o_count;

        if (i_byte == ChEnd) begin
            o_state = ST_WAIT_OPEN;
            o_count = '0;
        end
    end

endmodule
